### hw/rtl/string_literal_unescaper_top_defines.svh
// Assertion macros shared by the string literal unescaper RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef STRING_LITERAL_UNESCAPER_TOP_DEFINES_SVH
`define STRING_LITERAL_UNESCAPER_TOP_DEFINES_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define SLU_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define SLU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/slu_pkg.sv
// Types, codes and helper functions of the string literal unescaper.
// No dependencies; used by slu_step, slu_fifo and the top level.
package slu_pkg;

  typedef enum logic [6:0] {
    PH_OPEN  = 7'b0000001,
    PH_PLAIN = 7'b0000010,
    PH_BSL   = 7'b0000100,
    PH_X     = 7'b0001000,
    PH_HEX1  = 7'b0010000,
    PH_COPY  = 7'b0100000,
    PH_ERR   = 7'b1000000
  } slu_phase_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CUT  = 2'd1;
  localparam logic [1:0] ST_CTRL = 2'd2;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] HEX_BAD  = 8'hFF;

  typedef struct packed {
    slu_phase_t phase;
    logic [1:0] copy_left;
    logic [3:0] high_nibble;
  } slu_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic [1:0] status;
    logic       run_end;
  } slu_result_t;

  // Value of one hex digit, or all ones for anything else.
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = HEX_BAD;
    end
    return v;
  endfunction

endpackage

### hw/rtl/slu_step.sv
// Combinational step of the unescaper: one byte and the current state in,
// next state and up to two results out. Depends on slu_pkg.
module slu_step
  import slu_pkg::*;
(
  input  slu_state_t  cur,
  input  logic [7:0]  byte_in,
  input  logic        last_in,
  output slu_state_t  nxt,
  output slu_result_t res0,
  output slu_result_t res1,
  output logic [1:0]  res_n
);

  function automatic slu_result_t data_res(input logic [7:0] b);
    slu_result_t r;
    r.out_byte      = b;
    r.has_byte      = 1'b1;
    r.end_of_string = 1'b0;
    r.status        = ST_OK;
    r.run_end       = 1'b0;
    return r;
  endfunction

  logic [7:0] hv;

  always_comb begin
    hv    = hex_val(byte_in);
    nxt   = cur;
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;
    if (last_in) begin
      // Closing byte: one end-of-string result, state back to reset.
      res0.end_of_string = 1'b1;
      if (cur.phase == PH_BSL || cur.phase == PH_X || cur.phase == PH_HEX1) begin
        res0.status = ST_CUT;
      end else if (cur.phase == PH_ERR) begin
        res0.status = ST_CTRL;
      end else begin
        res0.status = ST_OK;
      end
      res_n           = 2'd1;
      nxt.phase       = PH_OPEN;
      nxt.copy_left   = 2'd0;
      nxt.high_nibble = 4'd0;
    end else begin
      case (cur.phase)
        PH_PLAIN: begin
          if (byte_in == CH_BSL) begin
            nxt.phase = PH_BSL;
          end else if (byte_in == CH_TAB || byte_in == CH_LF ||
                       byte_in == CH_BEL || byte_in == CH_CR) begin
            nxt.phase = PH_ERR;
          end else begin
            res0  = data_res(byte_in);
            res_n = 2'd1;
            if ((byte_in & 8'hE0) == 8'hC0) begin
              nxt.copy_left = 2'd1;
            end else if ((byte_in & 8'hF0) == 8'hE0) begin
              nxt.copy_left = 2'd2;
            end else if ((byte_in & 8'hF8) == 8'hF0) begin
              nxt.copy_left = 2'd3;
            end else begin
              nxt.copy_left = 2'd0;
            end
            if (nxt.copy_left != 2'd0) begin
              nxt.phase = PH_COPY;
            end
          end
        end
        PH_BSL: begin
          nxt.phase = PH_PLAIN;
          res_n     = 2'd1;
          case (byte_in)
            CH_N:     res0 = data_res(CH_LF);
            CH_R:     res0 = data_res(CH_CR);
            CH_B:     res0 = data_res(CH_BS);
            CH_T:     res0 = data_res(CH_TAB);
            CH_A:     res0 = data_res(CH_BEL);
            CH_DQUOT: res0 = data_res(CH_DQUOT);
            CH_SQUOT: res0 = data_res(CH_SQUOT);
            CH_BSL:   res0 = data_res(CH_BSL);
            CH_X: begin
              nxt.phase = PH_X;
              res_n     = 2'd0;
            end
            default: begin
              // Unknown escape passes through as backslash plus character.
              res0  = data_res(CH_BSL);
              res1  = data_res(byte_in);
              res_n = 2'd2;
            end
          endcase
        end
        PH_X: begin
          nxt.high_nibble = hv[3:0];
          nxt.phase       = PH_HEX1;
        end
        PH_HEX1: begin
          res0            = data_res({cur.high_nibble, 4'd0} | hv);
          res_n           = 2'd1;
          nxt.high_nibble = 4'd0;
          nxt.phase       = PH_PLAIN;
        end
        PH_COPY: begin
          res0          = data_res(byte_in);
          res_n         = 2'd1;
          nxt.copy_left = cur.copy_left - 2'd1;
          if (nxt.copy_left == 2'd0) begin
            nxt.phase = PH_PLAIN;
          end
        end
        PH_ERR: begin
          nxt = cur;
        end
        default: begin
          // Opening byte is swallowed.
          nxt.phase = PH_PLAIN;
        end
      endcase
    end
    if (res_n == 2'd1) begin
      res0.run_end = 1'b1;
    end
    if (res_n == 2'd2) begin
      res1.run_end = 1'b1;
    end
  end

endmodule

### hw/rtl/slu_fifo.sv
// Result queue of the unescaper: takes zero, one or two results a cycle
// and presents one at a time from a registered store. Depends on slu_pkg.
module slu_fifo
  import slu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 push_n,
  input  slu_result_t                push0,
  input  slu_result_t                push1,
  input  logic                       pop,
  output logic                       head_valid,
  output slu_result_t                head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  slu_result_t      mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign wr_ptr_p1 = wrap_inc(wr_ptr_r);

  always_comb begin
    rd_ptr_nxt = pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    case (push_n)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = wrap_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];
  assign count      = cnt_r;

endmodule

### hw/rtl/string_literal_unescaper_top.sv
// Top level of the string literal unescaper: input register, step logic
// and result queue. Depends on slu_pkg, slu_step, slu_fifo and the defines.
//
// Usage. A quoted literal enters on the in_ stream one byte per request,
// in_tdata carrying the byte and in_tlast marking the closing quote. The
// opening and closing bytes are dropped, escapes are expanded, and each
// resulting byte leaves on the out_ stream as one request. The closing
// byte produces a final request with out_tlast high, no data byte, and the
// literal's status in out_tuser.
// An accepted byte waits in the input register, then passes through the
// step logic into the result queue, whose head drives the out_ stream.
// Throughput is one input byte per cycle while the result queue has room;
// an unknown escape yields two results, which the single output port of
// the result queue presents one at a time.
// Input readiness depends only on registered state (input register and
// queue fill), so there is no combinational path from out_tready to
// in_tready. When the receiver stalls, the queue fills and then the input
// stalls; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the input register and queue and
// returns the parser to waiting for an opening quote.
`include "string_literal_unescaper_top_defines.svh"

module string_literal_unescaper_top
  import slu_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [3:0] out_tuser,  // [0] has_byte, [2:1] status, [3] run_end
  output logic       out_tlast   // end_of_string
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

  // Input register holding the accepted byte until the queue has room.
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  slu_state_t  state_r, state_nxt;
  slu_result_t res0, res1, head;
  logic [1:0]  res_n;
  logic [CNT_W-1:0] fifo_cnt, fifo_free;
  logic        consume, head_valid, pop;

  slu_step u_step (
    .cur     (state_r),
    .byte_in (in_byte_r),
    .last_in (in_last_r),
    .nxt     (state_nxt),
    .res0    (res0),
    .res1    (res1),
    .res_n   (res_n)
  );

  // The held byte is processed once the queue can take all its results.
  assign fifo_free = DEPTH_C - fifo_cnt;
  assign consume   = in_v_r && (fifo_free >= CNT_W'(res_n));
  assign in_tready = !in_v_r || consume;
  assign pop       = head_valid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      state_r <= '{phase: PH_OPEN, copy_left: 2'd0, high_nibble: 4'd0};
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (consume) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  slu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (consume ? res_n : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (fifo_cnt)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = head.out_byte;
  assign out_tuser  = {head.run_end, head.status, head.has_byte};
  assign out_tlast  = head.end_of_string;

  `SLU_ASSERT_NOW(a_status_only_at_end, out_tvalid && !out_tlast, out_tuser[2:1] == ST_OK, "error status on a data result")
  `SLU_ASSERT_NOW(a_end_closes_run, out_tvalid && out_tlast, out_tuser[3] && !out_tuser[0], "end-of-string result must close its run and carry no byte")
  `SLU_ASSERT_NOW(a_queue_bound, 1'b1, fifo_cnt <= DEPTH_C, "result queue over capacity")
  `SLU_ASSERT_NEXT(a_last_rearms, consume && in_last_r, state_r.phase == PH_OPEN, "parser not rearmed after closing byte")

endmodule
